[src/nls_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nls_pkg;

    // Widths of the fixed-point values (Q.30 scaling inside the block).
    localparam int VAL_W  = 46;   // operand << 14, and every reduced value
    localparam int ROOT_W = 38;   // result of one exact square root
    localparam int RAD_W  = 76;   // radicand v * 2^30
    localparam int REM_W  = 40;   // partial remainder of the root
    localparam int STEP_W = 6;    // root digit counter
    localparam int U_W    = 35;   // signed Horner accumulator
    localparam int T_W    = 32;   // signed reduced value minus one
    localparam int CNT_W  = 7;    // root count as seen by the output scaling
    localparam int OUT_W  = 21;

    // Q.30 constants.
    localparam logic [VAL_W-1:0] ONE_Q30    = 46'd1 << 30;
    localparam logic [VAL_W-1:0] HIGH_ENTRY = 46'd3 << 29;
    localparam logic [VAL_W-1:0] HIGH_STOP  = 46'd5 << 28;
    localparam logic [VAL_W-1:0] LOW_BOUND  = 46'd751619277;

    // Output limits as magnitudes.
    localparam logic [53:0] OUT_MAX     = 54'd1048575;
    localparam logic [53:0] OUT_NEG_MAG = 54'd1048576;

    // Status of the shared square-root unit.
    typedef struct packed {
        logic busy;
        logic done;
    } t_root_stat;

endpackage

`default_nettype wire

[src/nls_root.sv]
`timescale 1ns / 1ps
`default_nettype none

module nls_root
    import nls_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [VAL_W-1:0]  i_value,
    output t_root_stat             o_stat,
    output logic      [ROOT_W-1:0] o_root
);

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_q;
    logic [STEP_W-1:0] r_step;
    logic              r_busy;
    logic              r_done;

    logic [REM_W+1:0]  w_rem4;
    logic [REM_W+1:0]  w_trial;
    logic              w_take;

    // One result bit per cycle: bring down two radicand bits, try to subtract.
    assign w_rem4  = {r_rem, r_rad[RAD_W-1 -: 2]};
    assign w_trial = {2'b00, r_q, 2'b01};
    assign w_take  = (w_rem4 >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
            end else if (r_busy && r_step == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Datapath registers of the digit recurrence.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= {i_value, 30'd0};
            r_rem  <= '0;
            r_q    <= '0;
            r_step <= STEP_W'(ROOT_W - 1);
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_step <= r_step - 1'b1;
            if (w_take) begin
                r_rem <= REM_W'(w_rem4 - w_trial);
                r_q   <= {r_q[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem <= REM_W'(w_rem4);
                r_q   <= {r_q[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_q;

endmodule

`default_nettype wire

[src/natural_log_sqrt_reduction.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   | Direction | Handshake                          | Payload
// ----------+-----------+------------------------------------+--------------------------
// operand   | in        | i_operand_valid / o_operand_ready  | i_operand[31:0]
// result    | out       | o_result_valid / i_result_ready    | o_log_value[20:0], o_invalid
//
// A request enters the check state; each root passes the root state, where the shared
// unit runs its digit recurrence, and returns to the check state. Each of the TERMS
// Horner terms takes a multiply and an add state on the shared multiplier; the final
// state writes the result. A zero operand goes there from the check state. Reset is
// synchronous and active low; it empties the result register and returns the sequencer
// to idle. A stalled result holds its payload; the next request is taken while it waits.

module natural_log_sqrt_reduction
    import nls_pkg::*;
#(
    parameter int TERMS      = 100,
    parameter int ROOT_LIMIT = 50
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_operand_valid,
    output logic                         o_operand_ready,
    input  wire logic [31:0]             i_operand,
    output logic                         o_result_valid,
    input  wire logic                    i_result_ready,
    output logic signed [OUT_W-1:0]      o_log_value,
    output logic                         o_invalid
);

    localparam int IW = $clog2(TERMS + 1);
    localparam int CW = $clog2(ROOT_LIMIT + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_ROOT  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_ADD   = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;

    logic [2:0]             r_state;
    logic [VAL_W-1:0]       r_v;
    logic [CW-1:0]          r_count;
    logic                   r_hi;
    logic                   r_lo;
    logic                   r_zero;
    logic signed [T_W-1:0]  r_t;
    logic signed [U_W-1:0]  r_u;
    logic [IW-1:0]          r_idx;
    logic [63:0]            r_prod;
    logic                   r_pneg;

    // Coefficient table: +-round(2^30 / n), zero for n = 0.
    logic signed [32:0] w_coef [0:TERMS];

    for (genvar g = 0; g <= TERMS; g++) begin : g_coef
        localparam int DIV = (g == 0) ? 1 : g;
        localparam logic [32:0] CMAG = 33'(((64'd1 << 30) + 64'(g / 2)) / 64'(DIV));
        if (g == 0) begin : g_zero
            assign w_coef[g] = '0;
        end else if (g % 2 == 0) begin : g_even
            assign w_coef[g] = -$signed(CMAG);
        end else begin : g_odd
            assign w_coef[g] = $signed(CMAG);
        end
    end

    // Shared square-root unit.
    t_root_stat          w_root_stat;
    logic [ROOT_W-1:0]   w_root;
    logic                w_root_start;
    logic [VAL_W-1:0]    w_v_in;

    assign w_v_in = {i_operand, 14'd0};

    nls_root u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_root_start),
        .i_value (r_v),
        .o_stat  (w_root_stat),
        .o_root  (w_root)
    );

    // Decide whether another root is due.
    logic w_go;
    assign w_go = (r_count < CW'(ROOT_LIMIT)) &&
                  ((r_hi && r_v > HIGH_STOP) || (r_lo && r_v < LOW_BOUND));
    assign w_root_start = (r_state == S_CHECK) && !r_zero && w_go;

    // Magnitudes for the Horner multiply.
    logic [U_W-1:0] w_umag;
    logic [T_W-1:0] w_tmag;
    assign w_umag = r_u[U_W-1] ? U_W'(-r_u) : U_W'(r_u);
    assign w_tmag = r_t[T_W-1] ? T_W'(-r_t) : T_W'(r_t);

    // Rounded product back to Q.30, signed, plus the next coefficient.
    logic [63:0]           w_rnd;
    logic signed [U_W-1:0] w_m;
    logic signed [U_W-1:0] w_u_next;
    assign w_rnd    = r_prod + (64'd1 << 29);
    assign w_m      = $signed(U_W'(w_rnd[63:30]));
    assign w_u_next = (r_pneg ? -w_m : w_m) + U_W'(w_coef[r_idx]);

    // Scale by two to the root count, round and saturate.
    logic [CNT_W-1:0]      w_c7;
    logic [CNT_W-1:0]      w_sup;
    logic [3:0]            w_sdn;
    logic                  w_sat;
    logic [53:0]           w_q;
    logic [53:0]           w_lim;
    logic [53:0]           w_qc;
    logic                  w_neg;
    logic [OUT_W-1:0]      w_out;

    always_comb begin
        w_c7  = CNT_W'(r_count);
        w_sup = w_c7 - CNT_W'(14);
        w_sdn = 4'(CNT_W'(14) - w_c7);
        w_neg = r_u[U_W-1];
        w_sat = 1'b0;
        if (w_c7 >= CNT_W'(14)) begin
            w_sat = (w_umag != '0) && (w_sup >= CNT_W'(21));
            w_q   = 54'(w_umag) << w_sup[4:0];
        end else begin
            w_q = ((54'(w_umag) >> (w_sdn - 4'd1)) + 54'd1) >> 1;
        end
        w_lim = w_neg ? OUT_NEG_MAG : OUT_MAX;
        w_qc  = (w_sat || w_q > w_lim) ? w_lim : w_q;
        w_out = w_neg ? OUT_W'(-w_qc) : OUT_W'(w_qc);
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            o_result_valid <= 1'b0;
        end else begin
            // A result taken outside the final state empties the register.
            if (o_result_valid && i_result_ready && r_state != S_FIN) begin
                o_result_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_operand_valid) begin
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_zero) begin
                        r_state <= S_FIN;
                    end else if (w_go) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_state <= S_MUL;
                    end
                end
                S_ROOT: begin
                    if (w_root_stat.done) begin
                        r_state <= S_CHECK;
                    end
                end
                S_MUL: begin
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    r_state <= (r_idx == '0) ? S_FIN : S_MUL;
                end
                S_FIN: begin
                    if (!o_result_valid || i_result_ready) begin
                        o_result_valid <= 1'b1;
                        r_state        <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_operand_valid) begin
                    r_v     <= w_v_in;
                    r_count <= '0;
                    r_zero  <= (i_operand == '0);
                    r_hi    <= (w_v_in > HIGH_ENTRY);
                    r_lo    <= !(w_v_in > HIGH_ENTRY) && (w_v_in < LOW_BOUND);
                end
            end
            S_CHECK: begin
                if (!w_go) begin
                    r_t   <= T_W'(r_v - ONE_Q30);
                    r_u   <= U_W'(w_coef[TERMS]);
                    r_idx <= IW'(TERMS - 1);
                end
            end
            S_ROOT: begin
                if (w_root_stat.done) begin
                    r_v     <= VAL_W'(w_root);
                    r_count <= r_count + 1'b1;
                end
            end
            S_MUL: begin
                r_prod <= 64'(w_umag[32:0]) * 64'(w_tmag[30:0]);
                r_pneg <= r_u[U_W-1] ^ r_t[T_W-1];
            end
            S_ADD: begin
                r_u <= w_u_next;
                if (r_idx != '0) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
            S_FIN: begin
                if (!o_result_valid || i_result_ready) begin
                    o_invalid   <= r_zero;
                    o_log_value <= r_zero ? '0 : $signed(w_out);
                end
            end
            default: begin
            end
        endcase
    end

    assign o_operand_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

[src/nls_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module nls_checker
    import nls_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_operand_valid,
    input  wire logic                   o_operand_ready,
    input  wire logic                   o_result_valid,
    input  wire logic                   i_result_ready,
    input  wire logic signed [OUT_W-1:0] o_log_value,
    input  wire logic                   o_invalid
);

    // An invalid result always carries a zero log value.
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_invalid |-> o_log_value == '0)
        else $error("invalid result with nonzero log value");

    // After a request is taken the block is busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_operand_valid && o_operand_ready |=> !o_operand_ready)
        else $error("ready stayed high after a request");

    // A result never appears in the cycle right after a request is taken.
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_operand_valid && o_operand_ready && !o_result_valid |=> !o_result_valid)
        else $error("result appeared without computation");

    // A stalled result holds its valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !i_result_ready |=>
            o_result_valid && $stable(o_log_value) && $stable(o_invalid))
        else $error("stalled result changed");

    // Reset empties the result register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_result_valid)
        else $error("result valid after reset");

endmodule

bind natural_log_sqrt_reduction nls_checker u_nls_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_operand_valid (i_operand_valid),
    .o_operand_ready (o_operand_ready),
    .o_result_valid  (o_result_valid),
    .i_result_ready  (i_result_ready),
    .o_log_value     (o_log_value),
    .o_invalid       (o_invalid)
);

`default_nettype wire
